/* sv/wnpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wnpm_pkg;

  // Item codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 11;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRIES      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_RED   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_GREEN = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_BLUE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FLOOR        = 3'd4;

  localparam int ENTRIES_BITS = 9;
  localparam int WEIGHT_BITS  = 4;
  localparam int FLOOR_BITS   = 11;
  localparam int INDEX_BITS   = 8;

  localparam logic [ENTRIES_BITS-1:0] ENTRIES_RST = 9'd68;
  localparam logic [WEIGHT_BITS-1:0]  WRED_RST    = 4'd8;
  localparam logic [WEIGHT_BITS-1:0]  WGREEN_RST  = 4'd12;
  localparam logic [WEIGHT_BITS-1:0]  WBLUE_RST   = 4'd1;
  localparam logic [FLOOR_BITS-1:0]   FLOOR_RST   = 11'd51;

  // Distance limit is 10000.0 in squared-component units
  localparam int LIMIT_INT  = 10000;
  localparam int LIMIT_BITS = 14;

  typedef struct packed {
    logic [ENTRIES_BITS-1:0] entries_in_use;
    logic [WEIGHT_BITS-1:0]  weight_red;
    logic [WEIGHT_BITS-1:0]  weight_green;
    logic [WEIGHT_BITS-1:0]  weight_blue;
    logic [FLOOR_BITS-1:0]   intensity_floor;
  } cfg_t;

endpackage
`default_nettype wire

/* sv/wnpm_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// Command channel: palette writes and queries
interface wnpm_cmd_if #(parameter int COMPONENT_BITS = 10) ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [7:0]                entry_index;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;
  modport source (output valid, func, entry_index, red, green, blue, input ready);
  modport sink (input valid, func, entry_index, red, green, blue, output ready);
endinterface

// Result channel
interface wnpm_res_if ();
  logic       valid;
  logic       ready;
  logic [7:0] best_index;
  logic       not_found;
  modport source (output valid, best_index, not_found, input ready);
  modport sink (input valid, best_index, not_found, output ready);
endinterface

// Configuration write channel
interface wnpm_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/wnpm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module wnpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/wnpm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Takes commands, computes the intensity of the color and queues the item.
module wnpm_front #(
  parameter int COMPONENT_BITS = 10,
  parameter int ITEM_BITS = 1 + 8 + 4 * COMPONENT_BITS + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  wnpm_cmd_if.sink                  cmd,
  input  wire logic                 q_full,
  output logic                      q_push,
  output logic      [ITEM_BITS-1:0] q_item
);
  import wnpm_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int RB = CB + 1;
  localparam int SW = 2 * RB;
  localparam int BW = $clog2(RB);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_ROOT = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]            state;
  logic                  func;
  logic [INDEX_BITS-1:0] idx;
  logic [CB-1:0]         r, g, b;
  logic [SW-1:0]         sum;
  logic [RB-1:0]         root;
  logic [BW-1:0]         bitpos;
  logic [RB-1:0]         cand;
  logic [SW-1:0]         cand_sq;

  assign cmd.ready = (state == F_IDLE);
  assign q_push    = (state == F_PUSH) && !q_full;
  assign q_item    = {func, idx, r, g, b, root};

  // One root bit per cycle: keep the trial bit if its square still fits
  assign cand    = root | (RB'(1) << bitpos);
  assign cand_sq = cand * cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (cmd.valid) begin
            func  <= cmd.func;
            idx   <= cmd.entry_index;
            r     <= cmd.red;
            g     <= cmd.green;
            b     <= cmd.blue;
            state <= F_SQ;
          end
        end
        F_SQ: begin
          sum    <= SW'(r * r) + SW'(g * g) + SW'(b * b);
          root   <= '0;
          bitpos <= BW'(RB - 1);
          state  <= F_ROOT;
        end
        F_ROOT: begin
          if (cand_sq <= sum) begin
            root <= cand;
          end
          if (bitpos == '0) begin
            state <= F_PUSH;
          end else begin
            bitpos <= bitpos - 1'b1;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/wnpm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue between front and back
module wnpm_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign dout  = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/wnpm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Writes the palette and runs the per-entry scan for queries.
module wnpm_back #(
  parameter int PALETTE_SIZE = 256,
  parameter int COMPONENT_BITS = 10,
  parameter int ITEM_BITS = 1 + 8 + 4 * COMPONENT_BITS + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wnpm_pkg::cfg_t       cfg_regs,
  input  wire logic                 q_empty,
  input  wire logic [ITEM_BITS-1:0] q_head,
  output logic                      q_pop,
  wnpm_res_if.source                result
);
  import wnpm_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int RB = CB + 1;          // intensity
  localparam int NB = CB + 2;          // numerator factor
  localparam int PB = CB + NB;         // product
  localparam int QB = CB + 1;          // scaled component
  localparam int DB = CB + 2;          // divisor and remainder
  localparam int DW = 2 * QB + 6;      // distance
  localparam int LW = 2 * CB + LIMIT_BITS;
  localparam int FW = (RB > FLOOR_BITS) ? RB : FLOOR_BITS;
  localparam int AW = $clog2(PALETTE_SIZE);
  localparam int CW = $clog2(PALETTE_SIZE + 1);
  localparam int SB = $clog2(QB);
  localparam int EW = 3 * CB + RB;
  localparam logic [LW-1:0] DIST_LIMIT = LW'(LIMIT_INT) << (2 * CB);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_READ = 3'd1;
  localparam logic [2:0] B_LOAD = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_SQR  = 3'd4;
  localparam logic [2:0] B_WGT  = 3'd5;
  localparam logic [2:0] B_CMP  = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  // Queue head fields
  logic                  h_func;
  logic [INDEX_BITS-1:0] h_idx;
  logic [3*CB-1:0]       h_rgb;
  logic [RB-1:0]         h_int;
  assign {h_func, h_idx, h_rgb, h_int} = q_head;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [RB-1:0] src;
  logic [CB-1:0] qry_c [3];
  logic [DB-1:0] den;
  logic [DB-1:0] rem [3];
  logic [QB-1:0] low [3];
  logic [QB-1:0] q [3];
  logic [SB-1:0] step;
  logic [2*QB-1:0] sq [3];
  logic [DW-1:0] entry_dist;
  logic [LW-1:0] best_dist;
  logic [AW-1:0] best_i;
  logic          found;
  logic          res_load;

  // Palette store: {red, green, blue, intensity}
  logic          ram_we;
  logic [EW-1:0] rdata;
  logic [CB-1:0] ent_c [3];
  logic [RB-1:0] ent_int;
  logic [NB-1:0] num;
  logic          do_scale;

  assign ram_we = q_pop && (h_func == FUNC_WRITE) && (int'(h_idx) < PALETTE_SIZE);

  wnpm_ram #(.WIDTH(EW), .DEPTH(PALETTE_SIZE)) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (h_idx[AW-1:0]),
    .wdata ({h_rgb, h_int}),
    .raddr (i[AW-1:0]),
    .rdata (rdata)
  );

  assign {ent_c[0], ent_c[1], ent_c[2], ent_int} = rdata;
  assign num      = NB'(src) + NB'(ent_int);
  assign do_scale = FW'(ent_int) > FW'(cfg_regs.intensity_floor);

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign res_load = (state == B_OUT) && (!result.valid || result.ready);

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_pop && (h_func == FUNC_QUERY)) begin
            src       <= h_int;
            qry_c[0]  <= h_rgb[3*CB-1:2*CB];
            qry_c[1]  <= h_rgb[2*CB-1:CB];
            qry_c[2]  <= h_rgb[CB-1:0];
            i         <= '0;
            best_dist <= DIST_LIMIT;
            best_i    <= '0;
            found     <= 1'b0;
            if (int'(cfg_regs.entries_in_use) > PALETTE_SIZE) begin
              count <= CW'(PALETTE_SIZE);
            end else begin
              count <= CW'(cfg_regs.entries_in_use);
            end
            if (cfg_regs.entries_in_use == '0) begin
              state <= B_OUT;
            end else begin
              state <= B_READ;
            end
          end
        end
        B_READ: state <= B_LOAD;
        B_LOAD: begin
          // Numerators c * (S + C) split into leading remainder and low bits
          den  <= {ent_int, 1'b0};
          step <= SB'(QB - 1);
          for (int k = 0; k < 3; k++) begin
            rem[k] <= DB'(PB'(ent_c[k] * num) >> QB);
            low[k] <= QB'(ent_c[k] * num);
            q[k]   <= QB'(ent_c[k]);
          end
          state <= do_scale ? B_DIV : B_SQR;
        end
        B_DIV: begin
          // Restoring division, one quotient bit per lane per cycle
          for (int k = 0; k < 3; k++) begin
            if ({rem[k], low[k][QB-1]} >= {1'b0, den}) begin
              rem[k] <= DB'({rem[k], low[k][QB-1]} - {1'b0, den});
              q[k]   <= {q[k][QB-2:0], 1'b1};
            end else begin
              rem[k] <= DB'({rem[k], low[k][QB-1]});
              q[k]   <= {q[k][QB-2:0], 1'b0};
            end
            low[k] <= low[k] << 1;
          end
          if (step == '0) begin
            state <= B_SQR;
          end else begin
            step <= step - 1'b1;
          end
        end
        B_SQR: begin
          for (int k = 0; k < 3; k++) begin
            if (q[k] >= QB'(qry_c[k])) begin
              sq[k] <= (q[k] - QB'(qry_c[k])) * (q[k] - QB'(qry_c[k]));
            end else begin
              sq[k] <= (QB'(qry_c[k]) - q[k]) * (QB'(qry_c[k]) - q[k]);
            end
          end
          state <= B_WGT;
        end
        B_WGT: begin
          entry_dist <= DW'(cfg_regs.weight_red * sq[0])
                      + DW'(cfg_regs.weight_green * sq[1])
                      + DW'(cfg_regs.weight_blue * sq[2]);
          state <= B_CMP;
        end
        B_CMP: begin
          // Strict compare: lowest index wins a tie
          if (LW'(entry_dist) < best_dist) begin
            best_dist <= LW'(entry_dist);
            best_i    <= i[AW-1:0];
            found     <= 1'b1;
          end
          if (i == count - 1'b1) begin
            state <= B_OUT;
          end else begin
            i     <= i + 1'b1;
            state <= B_READ;
          end
        end
        B_OUT: begin
          if (res_load) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.best_index <= found ? INDEX_BITS'(best_i) : '0;
      result.not_found  <= !found;
    end
  end

endmodule
`default_nettype wire

/* sv/weighted_nearest_palette_match.sv */
`timescale 1ns / 1ps
`default_nettype none
// Weighted nearest palette match. Write commands (func 0) store an RGB entry and
// its intensity; query commands (func 1) return the index of the nearest entry
// under weight_red*dr^2 + weight_green*dg^2 + weight_blue*db^2, after each entry
// brighter than intensity_floor is rescaled toward the query intensity. The
// lowest index wins a tie. The front computes intensity with a one-bit-per-cycle
// square root. The back scans entries one after the other; an entry brighter
// than intensity_floor goes through a shared three-lane restoring divider
// producing one quotient bit per cycle, and any other entry skips it. A write
// is stored into the palette as the back pops it from the queue. A two-entry
// queue lets the front take the next command while the back scans. Entries
// must be written before a query scans them.
module weighted_nearest_palette_match #(
  parameter int PALETTE_SIZE = 256,
  parameter int COMPONENT_BITS = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  wnpm_cmd_if.sink  cmd,
  wnpm_res_if.source result,
  wnpm_cfg_if.sink  cfg
);
  import wnpm_pkg::*;

  localparam int IW = 1 + INDEX_BITS + 4 * COMPONENT_BITS + 1;

  cfg_t          cfg_regs;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [IW-1:0] q_item;
  logic [IW-1:0] q_head;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.entries_in_use  <= ENTRIES_RST;
      cfg_regs.weight_red      <= WRED_RST;
      cfg_regs.weight_green    <= WGREEN_RST;
      cfg_regs.weight_blue     <= WBLUE_RST;
      cfg_regs.intensity_floor <= FLOOR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ENTRIES:      cfg_regs.entries_in_use  <= cfg.data[ENTRIES_BITS-1:0];
        CFG_WEIGHT_RED:   cfg_regs.weight_red      <= cfg.data[WEIGHT_BITS-1:0];
        CFG_WEIGHT_GREEN: cfg_regs.weight_green    <= cfg.data[WEIGHT_BITS-1:0];
        CFG_WEIGHT_BLUE:  cfg_regs.weight_blue     <= cfg.data[WEIGHT_BITS-1:0];
        CFG_FLOOR:        cfg_regs.intensity_floor <= cfg.data[FLOOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  wnpm_front #(.COMPONENT_BITS(COMPONENT_BITS), .ITEM_BITS(IW)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  wnpm_queue #(.WIDTH(IW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_item),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  wnpm_back #(
    .PALETTE_SIZE   (PALETTE_SIZE),
    .COMPONENT_BITS (COMPONENT_BITS),
    .ITEM_BITS      (IW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .result   (result)
  );

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");
  a_nf_index: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.not_found) |-> (result.best_index == '0))
    else $error("not_found result carries nonzero index");
  a_rst_idle: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
